// File: rtl/core/sphc_pkg.sv
// sphc_pkg: types, constants and helper functions of the session packet
// header checker; used by the channel interfaces and the top level
package sphc_pkg;

	// packet size limit and the byte counter that saturates one past it
	localparam int unsigned MAX_PACKET_BYTES = 4096;
	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2);
	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_PACKET_BYTES + 1);

	// protocol layout
	localparam logic [7:0] PROTO_VERSION = 8'h01;
	localparam int unsigned ID_BYTES = 16;
	localparam logic [4:0] SHORT_HDR = 5'd7;
	localparam logic [4:0] LONG_HDR = 5'(3 + ID_BYTES + 4);

	// configuration port
	localparam int REG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ID_UPPER = 2'd0,
		REG_ID_LOWER = 2'd1,
		REG_ACTIVE   = 2'd2
	} reg_index_t;

	// verdict codes, first failing check wins
	typedef enum logic [2:0] {
		ST_OK              = 3'd0,
		ST_TOO_SHORT       = 3'd1,
		ST_BAD_VERSION     = 3'd2,
		ST_SHORT_HEADER    = 3'd3,
		ST_NO_SESSION      = 3'd4,
		ST_ID_MISMATCH     = 3'd5,
		ST_LENGTH_MISMATCH = 3'd6
	} status_t;

	// types that carry no session id
	function automatic logic sessionless_type(input logic [7:0] t);
		return (t == 8'h10) || (t == 8'h12) || (t == 8'h20) ||
			(t == 8'h22) || (t == 8'h23);
	endfunction

endpackage

// File: rtl/core/sphc_if.sv
// sphc_if: valid/ready channels of the session packet header checker
// depends on sphc_pkg for the verdict code type

// one packet byte per transaction
interface sphc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       last_byte;
	logic       check_session;

	modport source(output valid, packet_byte, last_byte, check_session, input ready);
	modport sink(input valid, packet_byte, last_byte, check_session, output ready);
endinterface

// one verdict per packet
interface sphc_result_if;
	logic              valid;
	logic              ready;
	sphc_pkg::status_t status;
	logic [7:0]        packet_type;
	logic [7:0]        flag_byte;
	logic [31:0]       payload_length;
	logic              is_sessionless;
	logic [4:0]        payload_offset;

	modport source(output valid, status, packet_type, flag_byte, payload_length,
		is_sessionless, payload_offset, input ready);
	modport sink(input valid, status, packet_type, flag_byte, payload_length,
		is_sessionless, payload_offset, output ready);
endinterface

// File: rtl/core/session_packet_header_checker_top.sv
// session_packet_header_checker_top: byte-wise packet header checker
// depends on sphc_pkg and the channel interfaces in sphc_if
//
// Usage:
//   pkt carries one packet byte per transaction, with last_byte on the final
//   byte and check_session sampled on the first byte of each packet.
//   verdict carries one transaction per packet, produced by its last byte:
//   status, captured type, flag and size, sessionless mark and header length.
//   wr_en/wr_index/wr_data write the expected session id and the session
//   active bit; write only while no packet is in flight.
// Throughput: one byte per cycle unless a last byte is held by an occupied
//   verdict register; the per-byte work is a counter step, a field capture
//   and one id byte compare between the input register and the verdict register.
// Path: a taken last byte loads the input register first; its verdict is
//   loaded into the verdict register when that byte leaves the input
//   register, which a still occupied verdict register can hold back.
// Reset: all packet state, the id registers and the active bit clear; no
//   transaction is pending on either channel.
// Stall: a held verdict keeps its value; bytes keep flowing while the
//   verdict waits, until a further last byte finds the verdict register
//   still occupied, which then holds the input register and drops ready.
module session_packet_header_checker_top (
	input  logic                                clk,
	input  logic                                arst_n,
	sphc_byte_if.sink                           pkt,
	sphc_result_if.source                       verdict,
	input  logic                                wr_en,
	input  logic [sphc_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [sphc_pkg::CFG_DATA_W-1:0]     wr_data
);
	import sphc_pkg::*;

	// configuration registers
	logic [63:0] id_upper_q;
	logic [63:0] id_lower_q;
	logic        active_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       check_s1;

	// packet state
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       version_q;
	logic [7:0]       type_q;
	logic [7:0]       flag_q;
	logic [31:0]      size_q;
	logic             mismatch_q;
	logic             check_q;

	// verdict register
	logic        out_valid_q;
	status_t     status_q;
	logic [7:0]  ptype_q;
	logic [7:0]  pflag_q;
	logic [31:0] plen_q;
	logic        sl_q;
	logic [4:0]  offset_q;

	// next packet state and verdict
	logic [CNT_W-1:0] cnt_n;
	logic [7:0]       version_n;
	logic [7:0]       type_n;
	logic [7:0]       flag_n;
	logic [31:0]      size_n;
	logic             mismatch_n;
	logic             check_n;
	logic             sl_n;
	logic [4:0]       hdr_n;
	status_t          status_n;
	logic [15:0][7:0] id_bytes;
	logic [3:0]       id_idx;
	logic [CNT_W-1:0] id_off;
	logic             in_acc;
	logic             advance;

	// handshake: a non-last byte always moves on, a last byte needs the verdict slot
	assign advance = valid_s1 && (!last_s1 || !out_valid_q || verdict.ready);
	assign pkt.ready = !valid_s1 || advance;
	assign in_acc = pkt.valid && pkt.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_upper_q <= '0;
			id_lower_q <= '0;
			active_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ID_UPPER: id_upper_q <= wr_data;
				REG_ID_LOWER: id_lower_q <= wr_data;
				REG_ACTIVE:   active_q   <= wr_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1  <= pkt.packet_byte;
			last_s1  <= pkt.last_byte;
			check_s1 <= pkt.check_session;
		end
	end

	// expected id byte, byte 0 is the top byte of the upper word
	assign id_bytes = {id_upper_q, id_lower_q};
	assign id_off = cnt_q - CNT_W'(3);
	assign id_idx = 4'd15 - id_off[3:0];

	// per-byte field capture
	always_comb begin
		version_n  = version_q;
		type_n     = type_q;
		flag_n     = flag_q;
		size_n     = size_q;
		mismatch_n = mismatch_q;
		check_n    = check_q;
		sl_n       = sessionless_type(type_q);
		priority if (cnt_q == CNT_W'(0)) begin
			version_n = byte_s1;
			check_n   = check_s1;
		end else if (cnt_q == CNT_W'(1)) begin
			type_n = byte_s1;
			sl_n   = sessionless_type(byte_s1);
		end else if (cnt_q == CNT_W'(2)) begin
			flag_n = byte_s1;
		end else if (sl_n) begin
			if (cnt_q < CNT_W'(SHORT_HDR))
				size_n = {size_q[23:0], byte_s1};
		end else if (cnt_q < CNT_W'(3 + ID_BYTES)) begin
			if (byte_s1 != id_bytes[id_idx])
				mismatch_n = 1'b1;
		end else if (cnt_q < CNT_W'(LONG_HDR)) begin
			size_n = {size_q[23:0], byte_s1};
		end else begin
			// payload byte, only counted
		end
		cnt_n = (cnt_q < CNT_SAT) ? cnt_q + CNT_W'(1) : cnt_q;
		hdr_n = sl_n ? SHORT_HDR : LONG_HDR;
	end

	// verdict, first failing check wins
	always_comb begin
		priority if (cnt_n < CNT_W'(SHORT_HDR))
			status_n = ST_TOO_SHORT;
		else if (version_n != PROTO_VERSION)
			status_n = ST_BAD_VERSION;
		else if (cnt_n < CNT_W'(hdr_n))
			status_n = ST_SHORT_HEADER;
		else if (!sl_n && check_n && !active_q)
			status_n = ST_NO_SESSION;
		else if (!sl_n && check_n && mismatch_n)
			status_n = ST_ID_MISMATCH;
		else if (cnt_n == CNT_SAT ||
			({1'b0, size_n} + 33'(hdr_n)) != 33'(cnt_n))
			status_n = ST_LENGTH_MISMATCH;
		else
			status_n = ST_OK;
	end

	// packet state, cleared after each last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			version_q  <= '0;
			type_q     <= '0;
			flag_q     <= '0;
			size_q     <= '0;
			mismatch_q <= 1'b0;
			check_q    <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				cnt_q      <= '0;
				version_q  <= '0;
				type_q     <= '0;
				flag_q     <= '0;
				size_q     <= '0;
				mismatch_q <= 1'b0;
				check_q    <= 1'b0;
			end else begin
				cnt_q      <= cnt_n;
				version_q  <= version_n;
				type_q     <= type_n;
				flag_q     <= flag_n;
				size_q     <= size_n;
				mismatch_q <= mismatch_n;
				check_q    <= check_n;
			end
		end
	end

	// verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= status_n;
			ptype_q  <= type_n;
			pflag_q  <= flag_n;
			plen_q   <= size_n;
			sl_q     <= sl_n;
			offset_q <= hdr_n;
		end
	end

	assign verdict.valid          = out_valid_q;
	assign verdict.status         = status_q;
	assign verdict.packet_type    = ptype_q;
	assign verdict.flag_byte      = pflag_q;
	assign verdict.payload_length = plen_q;
	assign verdict.is_sessionless = sl_q;
	assign verdict.payload_offset = offset_q;

`ifndef SYNTHESIS
	// a new verdict only follows a last byte leaving the input register
	a_verdict_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("verdict raised without a last byte");

	// the packet state is clear after every last byte
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (cnt_q == '0 && size_q == '0 && !mismatch_q))
		else $error("packet state not cleared after last byte");

	// the byte counter saturates
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_SAT)
		else $error("byte counter past saturation");

	// a last byte never overwrites a verdict that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !verdict.ready) |-> !(advance && last_s1))
		else $error("pending verdict overwritten");
`endif

endmodule

// File: sim/tb_session_packet_header_checker_top.sv
// tb_session_packet_header_checker_top: self-checking bench for the packet header checker
// depends on sphc_pkg, the channel interfaces in sphc_if and the checker top level
// packets go in byte by byte with random gaps, verdicts are checked against a local predictor
module tb_session_packet_header_checker_top;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       chk;
	} pkt_byte_t;

	typedef struct packed {
		sphc_pkg::status_t status;
		logic [7:0]        ptype;
		logic [7:0]        flag;
		logic [31:0]       plen;
		logic              idless;
		logic [4:0]        offset;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [sphc_pkg::REG_IDX_W-1:0] wr_index;
	logic [sphc_pkg::CFG_DATA_W-1:0] wr_data;

	sphc_byte_if pkt_ch();
	sphc_result_if res_ch();

	session_packet_header_checker_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt(pkt_ch),
		.verdict(res_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// stimulus and expectations
	pkt_byte_t   byte_q[$];
	verdict_t    verdict_q[$];
	logic [7:0]  pkt_buf[$];
	int unsigned bytes_queued;
	int unsigned mismatches;

	// predictor copy of registers and packet state
	logic [63:0] id_upper_r;
	logic [63:0] id_lower_r;
	logic        active_r;
	int unsigned cnt_r;
	logic [7:0]  ver_r;
	logic [7:0]  typ_r;
	logic [7:0]  flg_r;
	logic [31:0] size_r;
	logic        idmis_r;
	logic        chk_r;

	// driver and receiver pacing
	pkt_byte_t   tx_item;
	bit          tx_busy;
	int unsigned tx_wait;
	int unsigned rx_wait;
	bit          tx_calm;
	bit          rx_calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic id_free(input logic [7:0] t);
		return t == 8'h10 || t == 8'h12 || t == 8'h20 || t == 8'h22 || t == 8'h23;
	endfunction

	function automatic int unsigned draw_wait(input bit calm);
		if (calm)
			return 0;
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, 18);
		return $urandom_range(0, 2);
	endfunction

	// predictor step for one accepted byte; a last byte queues the expected verdict
	task automatic predict_verdict(input pkt_byte_t it);
		int unsigned pos;
		int unsigned k;
		logic        sl;
		logic [4:0]  hdr;
		logic [63:0] w;
		logic [7:0]  want;
		longint unsigned span;
		verdict_t    v;
		pos = cnt_r;
		sl = id_free(typ_r);
		if (pos == 0) begin
			ver_r = it.data;
			chk_r = it.chk;
		end else if (pos == 1) begin
			typ_r = it.data;
			sl = id_free(it.data);
		end else if (pos == 2) begin
			flg_r = it.data;
		end else if (sl) begin
			if (pos < 7)
				size_r = {size_r[23:0], it.data};
		end else if (pos < 19) begin
			k = pos - 3;
			w = (k < 8) ? id_upper_r : id_lower_r;
			want = w[63 - 8 * (k % 8) -: 8];
			if (it.data != want)
				idmis_r = 1'b1;
		end else if (pos < 23) begin
			size_r = {size_r[23:0], it.data};
		end
		if (cnt_r < sphc_pkg::MAX_PACKET_BYTES + 1)
			cnt_r++;
		if (!it.last)
			return;
		hdr = sl ? 5'd7 : 5'd23;
		span = longint'(hdr) + longint'(size_r);
		if (cnt_r < 7)
			v.status = sphc_pkg::ST_TOO_SHORT;
		else if (ver_r != sphc_pkg::PROTO_VERSION)
			v.status = sphc_pkg::ST_BAD_VERSION;
		else if (cnt_r < hdr)
			v.status = sphc_pkg::ST_SHORT_HEADER;
		else if (!sl && chk_r && !active_r)
			v.status = sphc_pkg::ST_NO_SESSION;
		else if (!sl && chk_r && idmis_r)
			v.status = sphc_pkg::ST_ID_MISMATCH;
		else if (cnt_r > sphc_pkg::MAX_PACKET_BYTES || span != longint'(cnt_r))
			v.status = sphc_pkg::ST_LENGTH_MISMATCH;
		else
			v.status = sphc_pkg::ST_OK;
		v.ptype = typ_r;
		v.flag = flg_r;
		v.plen = size_r;
		v.idless = sl;
		v.offset = hdr;
		verdict_q.push_back(v);
		cnt_r = 0;
		ver_r = '0;
		typ_r = '0;
		flg_r = '0;
		size_r = '0;
		idmis_r = 1'b0;
		chk_r = 1'b0;
	endtask

	task automatic report_mismatch(input verdict_t e, input verdict_t a, input bit orphan);
		mismatches++;
		if (mismatches <= 10) begin
			if (orphan)
				$display("verdict with none expected: st=%0d type=%02h flag=%02h len=%08h sl=%0b off=%0d",
					a.status, a.ptype, a.flag, a.plen, a.idless, a.offset);
			else
				$display("verdict mismatch: exp st=%0d type=%02h flag=%02h len=%08h sl=%0b off=%0d, got st=%0d type=%02h flag=%02h len=%08h sl=%0b off=%0d",
					e.status, e.ptype, e.flag, e.plen, e.idless, e.offset,
					a.status, a.ptype, a.flag, a.plen, a.idless, a.offset);
		end
	endtask

	// byte driver, changes inputs on the falling edge
	always @(negedge clk) begin
		if (!tx_busy) begin
			if (arst_n && tx_wait == 0 && byte_q.size() != 0) begin
				tx_item = byte_q.pop_front();
				pkt_ch.valid <= 1'b1;
				pkt_ch.packet_byte <= tx_item.data;
				pkt_ch.last_byte <= tx_item.last;
				pkt_ch.check_session <= tx_item.chk;
				tx_busy = 1'b1;
			end else begin
				pkt_ch.valid <= 1'b0;
				if (tx_wait != 0)
					tx_wait--;
			end
		end
	end

	// byte transaction accepted: feed the predictor
	always @(posedge clk) begin
		if (arst_n && pkt_ch.valid && pkt_ch.ready) begin
			predict_verdict(tx_item);
			tx_busy = 1'b0;
			if ($urandom_range(0, 150) == 0)
				tx_calm = !tx_calm;
			tx_wait = draw_wait(tx_calm);
		end
	end

	// verdict ready, held low for the drawn stall before each transaction
	always @(negedge clk) begin
		if (rx_wait != 0) begin
			res_ch.ready <= 1'b0;
			rx_wait--;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// verdict transaction accepted: compare with the oldest expectation
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.status = res_ch.status;
			got.ptype = res_ch.packet_type;
			got.flag = res_ch.flag_byte;
			got.plen = res_ch.payload_length;
			got.idless = res_ch.is_sessionless;
			got.offset = res_ch.payload_offset;
			if (verdict_q.size() == 0) begin
				report_mismatch(got, got, 1'b1);
			end else begin
				want = verdict_q.pop_front();
				if (got.status !== want.status || got.ptype !== want.ptype ||
					got.flag !== want.flag || got.plen !== want.plen ||
					got.idless !== want.idless || got.offset !== want.offset)
					report_mismatch(want, got, 1'b0);
			end
			if ($urandom_range(0, 40) == 0)
				rx_calm = !rx_calm;
			rx_wait = draw_wait(rx_calm);
		end
	end

	task automatic write_reg(input sphc_pkg::reg_index_t idx, input logic [63:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			sphc_pkg::REG_ID_UPPER: id_upper_r = val;
			sphc_pkg::REG_ID_LOWER: id_lower_r = val;
			sphc_pkg::REG_ACTIVE: active_r = val[0];
			default: ;
		endcase
	endtask

	task automatic set_session(input logic [63:0] up, input logic [63:0] lo, input logic act);
		write_reg(sphc_pkg::REG_ID_UPPER, up);
		write_reg(sphc_pkg::REG_ID_LOWER, lo);
		write_reg(sphc_pkg::REG_ACTIVE, {{63{$urandom_range(0, 1) == 1}}, act});
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// wait until every byte is taken and every verdict has come, then let the pipe settle
	task automatic drain;
		while (byte_q.size() != 0 || tx_busy || verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// header then payload into the scratch buffer
	task automatic fill_pkt_buf(input logic [7:0] ver, input logic [7:0] typ,
		input logic [7:0] flg, input logic [127:0] id, input logic [31:0] size_f,
		input int unsigned n_pay);
		pkt_buf.delete();
		pkt_buf.push_back(ver);
		pkt_buf.push_back(typ);
		pkt_buf.push_back(flg);
		if (!id_free(typ))
			for (int k = 0; k < 16; k++)
				pkt_buf.push_back(id[127 - 8 * k -: 8]);
		for (int k = 0; k < 4; k++)
			pkt_buf.push_back(size_f[31 - 8 * k -: 8]);
		repeat (n_pay)
			pkt_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	// scratch buffer to the byte queue; check_session only counts on the first byte
	task automatic queue_pkt_buf(input logic chk);
		pkt_byte_t it;
		for (int i = 0; i < pkt_buf.size(); i++) begin
			it.data = pkt_buf[i];
			it.last = (i == pkt_buf.size() - 1);
			it.chk = (i == 0) ? chk : 1'($urandom_range(0, 1));
			byte_q.push_back(it);
			bytes_queued++;
		end
	endtask

	task automatic cut_packet(input int unsigned keep);
		while (pkt_buf.size() > keep)
			void'(pkt_buf.pop_back());
	endtask

	// mostly well-formed packets with random content, some broken and some noise
	task automatic random_packet;
		logic [7:0]   ver;
		logic [7:0]   typ;
		logic [127:0] id;
		logic [31:0]  sz;
		int unsigned  n;
		if ($urandom_range(0, 19) == 0) begin
			pkt_buf.delete();
			repeat ($urandom_range(1, 30))
				pkt_buf.push_back(8'($urandom_range(0, 255)));
			queue_pkt_buf(1'($urandom_range(0, 1)));
			return;
		end
		ver = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : sphc_pkg::PROTO_VERSION;
		case ($urandom_range(0, 9))
			0: typ = 8'h10;
			1: typ = 8'h12;
			2: typ = 8'h20;
			3: typ = 8'h22;
			4: typ = 8'h23;
			default: typ = 8'($urandom_range(0, 255));
		endcase
		id = {id_upper_r, id_lower_r};
		if ($urandom_range(0, 4) == 0)
			id = id ^ (128'b1 << $urandom_range(0, 127));
		n = $urandom_range(0, 12);
		sz = n;
		case ($urandom_range(0, 9))
			0: sz = $urandom;
			1: sz = n + 1;
			2: sz = n - 1;
			default: ;
		endcase
		fill_pkt_buf(ver, typ, 8'($urandom_range(0, 255)), id, sz, n);
		if ($urandom_range(0, 9) == 0)
			cut_packet($urandom_range(1, pkt_buf.size()));
		queue_pkt_buf($urandom_range(0, 9) < 7);
	endtask

	task automatic random_phase(input logic [63:0] up, input logic [63:0] lo, input logic act);
		int unsigned goal;
		set_session(up, lo, act);
		goal = bytes_queued + 220;
		while (bytes_queued < goal)
			random_packet();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = sphc_pkg::REG_ID_UPPER;
		wr_data = '0;
		pkt_ch.valid = 1'b0;
		pkt_ch.packet_byte = '0;
		pkt_ch.last_byte = 1'b0;
		pkt_ch.check_session = 1'b0;
		res_ch.ready = 1'b0;
		bytes_queued = 0;
		mismatches = 0;
		id_upper_r = '0;
		id_lower_r = '0;
		active_r = 1'b0;
		cnt_r = 0;
		ver_r = '0;
		typ_r = '0;
		flg_r = '0;
		size_r = '0;
		idmis_r = 1'b0;
		chk_r = 1'b0;
		tx_busy = 1'b0;
		tx_wait = 0;
		rx_wait = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, no session open
		set_session('0, '0, 1'b0);
		fill_pkt_buf(8'h01, 8'h10, 8'h00, '0, 32'd0, 0);
		queue_pkt_buf(1'b1);
		pkt_buf.delete();
		pkt_buf.push_back(8'hff);
		queue_pkt_buf(1'b0);
		fill_pkt_buf(8'h00, 8'h12, 8'hff, '0, 32'd0, 0);
		queue_pkt_buf(1'b0);
		fill_pkt_buf(8'h01, 8'h01, 8'h5a, '0, 32'd0, 0);
		queue_pkt_buf(1'b1);
		drain();

		// directed, session open with a known id
		set_session(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
		fill_pkt_buf(8'h01, 8'hff, 8'hff, {id_upper_r, id_lower_r}, 32'd0, 0);
		queue_pkt_buf(1'b1);
		fill_pkt_buf(8'h01, 8'h00, 8'h00, ~{id_upper_r, id_lower_r}, 32'd0, 0);
		queue_pkt_buf(1'b1);
		fill_pkt_buf(8'h01, 8'h00, 8'h00, ~{id_upper_r, id_lower_r}, 32'd0, 0);
		queue_pkt_buf(1'b0);
		fill_pkt_buf(8'h01, 8'h30, 8'h00, '0, 32'd0, 0);
		cut_packet(10);
		queue_pkt_buf(1'b1);
		fill_pkt_buf(8'h01, 8'h23, 8'h81, '0, 32'hffffffff, 1);
		queue_pkt_buf(1'b0);
		fill_pkt_buf(8'h01, 8'h20, 8'h00, '0, 32'd2, 2);
		cut_packet(4);
		queue_pkt_buf(1'b0);
		drain();

		// random phases across register settings
		random_phase('1, '1, 1'b1);
		random_phase({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
		random_phase({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
		random_phase('0, '0, 1'b1);
		random_phase({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
		random_phase(64'h8000000000000001, 64'h7ffffffffffffffe, 1'b1);

		// a last round of random packets under a fresh id
		set_session({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
		repeat (20)
			random_packet();
		drain();

		if (mismatches == 0 && verdict_q.size() == 0)
			$display("session_packet_header_checker_top verification clean");
		else
			$display("session_packet_header_checker_top verification failed");
		$finish;
	end

	// run limit
	initial begin
		#20000000;
		$display("session_packet_header_checker_top verification failed");
		$finish;
	end

endmodule

// File: session_packet_header_checker_top.f
rtl/core/sphc_pkg.sv
rtl/core/sphc_if.sv
rtl/core/session_packet_header_checker_top.sv
sim/tb_session_packet_header_checker_top.sv
